@@ rtl/rc_channel_to_speed_mapper_macros.svh @@
// Assertion macros shared by the speed mapper checker.
// No dependencies; expects clk and rst_n in the using scope.
`ifndef RC_CHANNEL_TO_SPEED_MAPPER_MACROS_SVH
`define RC_CHANNEL_TO_SPEED_MAPPER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define RCSM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define RCSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/rcsm_pkg.sv @@
// Shared constants and types for the RC channel to speed mapper.
// No dependencies.
`default_nettype none

package rcsm_pkg;

  localparam int FIELD_W    = 16;
  localparam int MAXSPD_W   = 15;
  localparam int AGE_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int NUM_AXES   = 3;
  localparam int NUM_SW     = 2;

  // serial scaler sizing: product of a 16-bit distance and a 15-bit speed
  localparam int PROD_W    = FIELD_W + MAXSPD_W;
  localparam int MUL_STEPS = MAXSPD_W;
  localparam int DIV_STEPS = PROD_W;
  localparam int CNT_W     = 5;

  // axis lanes: forward, strafe, rotate; strafe and rotate are positive below centre
  localparam logic [NUM_AXES-1:0] LANE_BELOW_POS = 3'b110;

  localparam logic [CFG_IDX_W-1:0] CFG_FWD_LIM  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STR_LIM  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_LIM  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SWA_LIM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SWB_LIM  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPD  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SW_TOL   = 3'd7;

  typedef struct packed {
    logic [FIELD_W-1:0] delta;
    logic [FIELD_W-1:0] span;
  } scl_op_t;

  typedef struct packed {
    logic                busy;
    logic [MAXSPD_W-1:0] mag;
  } scl_res_t;

endpackage

`default_nettype wire

@@ rtl/rcsm_scaler.sv @@
// Bit-serial scaler: mag = min(delta * max_speed / span, 32767).
// Shift-add multiply then restoring divide; uses rcsm_pkg.
`default_nettype none

module rcsm_scaler (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire rcsm_pkg::scl_op_t            op,
  input  wire logic [rcsm_pkg::MAXSPD_W-1:0] max_speed,
  output      rcsm_pkg::scl_res_t           res
);
  import rcsm_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_DIV  = 2'd2;

  logic [1:0]         phase_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [PROD_W-1:0]  acc_r;     // multiplier/product, then dividend/quotient
  logic [FIELD_W-1:0] rem_r;
  logic [FIELD_W-1:0] dist_r;
  logic [FIELD_W-1:0] span_r;

  logic [FIELD_W:0]   mul_sum;
  logic [FIELD_W:0]   div_trial;
  logic               div_ge;
  logic [FIELD_W:0]   div_diff;

  assign mul_sum   = {1'b0, acc_r[PROD_W-1:MAXSPD_W]}
                   + (acc_r[0] ? {1'b0, dist_r} : '0);
  assign div_trial = {rem_r, acc_r[PROD_W-1]};
  assign div_ge    = div_trial >= {1'b0, span_r};
  assign div_diff  = div_trial - {1'b0, span_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
          if (start) begin
            phase_r <= PH_MUL;
            cnt_r   <= '0;
          end
        end
        PH_MUL: begin
          if (cnt_r == CNT_W'(MUL_STEPS - 1)) begin
            phase_r <= PH_DIV;
            cnt_r   <= '0;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        PH_DIV: begin
          if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
            phase_r <= PH_IDLE;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        default: phase_r <= PH_IDLE;
      endcase
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    unique case (phase_r)
      PH_IDLE: begin
        if (start) begin
          acc_r  <= {{FIELD_W{1'b0}}, max_speed};
          dist_r <= op.delta;
          span_r <= op.span;
        end
      end
      PH_MUL: begin
        acc_r <= {mul_sum, acc_r[MAXSPD_W-1:1]};
        rem_r <= '0;
      end
      PH_DIV: begin
        acc_r <= {acc_r[PROD_W-2:0], div_ge};
        rem_r <= div_ge ? div_diff[FIELD_W-1:0] : div_trial[FIELD_W-1:0];
      end
      default: ;
    endcase
  end

  assign res = '{busy: (phase_r != PH_IDLE),
                 mag:  (|acc_r[PROD_W-1:MAXSPD_W]) ? {MAXSPD_W{1'b1}}
                                                    : acc_r[MAXSPD_W-1:0]};

endmodule

`default_nettype wire

@@ rtl/rc_channel_to_speed_mapper.sv @@
// RC channel to speed mapper with receiver failsafe: top level.
// Uses rcsm_pkg and three rcsm_scaler lanes.
//
// One input beat per control tick carries the frame-done and link-up flags plus
// raw stick and switch channels; one result beat comes back for each. A
// saturating frame-age counter (reset to TIMEOUT_TICKS, offline) is cleared by
// frame_done and counts up otherwise; the receiver is online while link_up is
// high and the age is below TIMEOUT_TICKS. Both arm switches must lie in
// [up, down] and within switch_tolerance of down, otherwise (or when offline)
// the result is an emergency stop with all speeds zero. Each stick is clamped,
// a centre deadzone applied (edges wrap at 16 bits) and each side scaled to a
// signed speed, saturated at 32767 magnitude. From acceptance a beat passes
// the clamp and setup states, then a start to the lanes, where each axis lane
// runs a bit-serial multiply and restoring divide; the three lanes run side by
// side. The result register is then loaded once it is free, and the block
// returns to idle, where the next beat is taken. The result register is
// separate, so a finished result may wait on out_stall while the next beat is
// already accepted and being worked. Configuration writes are always ready
// and must only be made while the block is idle.
`default_nettype none

module rc_channel_to_speed_mapper #(
  parameter int TIMEOUT_TICKS = 20
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // input channel
  input  wire logic                               in_valid,
  output      logic                               in_stall,
  input  wire logic                               in_frame_done,
  input  wire logic                               in_link_up,
  input  wire logic [rcsm_pkg::FIELD_W-1:0]       in_forward_raw,
  input  wire logic [rcsm_pkg::FIELD_W-1:0]       in_strafe_raw,
  input  wire logic [rcsm_pkg::FIELD_W-1:0]       in_rotate_raw,
  input  wire logic [rcsm_pkg::FIELD_W-1:0]       in_switch_a_raw,
  input  wire logic [rcsm_pkg::FIELD_W-1:0]       in_switch_b_raw,
  // result channel
  output      logic                               out_valid,
  input  wire logic                               out_stall,
  output      logic                               out_rx_online,
  output      logic                               out_drive_en,
  output      logic                               out_estop_active,
  output      logic signed [rcsm_pkg::FIELD_W-1:0] out_fwd_spd,
  output      logic signed [rcsm_pkg::FIELD_W-1:0] out_str_spd,
  output      logic signed [rcsm_pkg::FIELD_W-1:0] out_rot_spd,
  // configuration
  input  wire logic                               cfg_valid,
  output      logic                               cfg_ready,
  input  wire logic [rcsm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rcsm_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import rcsm_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CLAMP = 2'd1;
  localparam logic [1:0] S_SETUP = 2'd2;
  localparam logic [1:0] S_RUN   = 2'd3;

  localparam logic [AGE_W-1:0] AGE_LIMIT = AGE_W'(TIMEOUT_TICKS);

  // configuration registers
  logic [CFG_DATA_W-1:0] stick_lim_r [NUM_AXES];
  logic [2*FIELD_W-1:0]  sw_lim_r    [NUM_SW];
  logic [FIELD_W-1:0]    deadzone_r;
  logic [MAXSPD_W-1:0]   max_speed_r;
  logic [FIELD_W-1:0]    sw_tol_r;

  // control
  logic [1:0]       state_r, state_nxt;
  logic [AGE_W-1:0] age_r, age_nxt;
  logic             in_acc;
  logic             out_free;
  logic             out_load;
  logic             start_r;
  logic             lanes_busy;

  // per-beat working registers
  logic               online_r;
  logic               sw_ok_r;
  logic [FIELD_W-1:0] stick_raw_r [NUM_AXES];
  logic [FIELD_W-1:0] sw_raw_r    [NUM_SW];
  logic [FIELD_W-1:0] v_r         [NUM_AXES];
  logic [FIELD_W-1:0] le_r        [NUM_AXES];
  logic [FIELD_W-1:0] ue_r        [NUM_AXES];
  scl_op_t            op_r        [NUM_AXES];
  logic [NUM_AXES-1:0] neg_r;
  logic [NUM_AXES-1:0] zero_r;

  // clamp stage logic
  logic [FIELD_W-1:0] lo_c [NUM_AXES];
  logic [FIELD_W-1:0] ce_c [NUM_AXES];
  logic [FIELD_W-1:0] hi_c [NUM_AXES];
  logic [FIELD_W-1:0] v_c  [NUM_AXES];
  logic [NUM_SW-1:0]  sw_ok_c;
  logic [FIELD_W-1:0] sw_up_c   [NUM_SW];
  logic [FIELD_W-1:0] sw_down_c [NUM_SW];
  logic [FIELD_W-1:0] sw_dist_c [NUM_SW];

  // setup stage logic
  scl_op_t             op_c  [NUM_AXES];
  logic [NUM_AXES-1:0] neg_c;
  logic [NUM_AXES-1:0] zero_c;
  logic [NUM_AXES-1:0] below_c;
  logic [NUM_AXES-1:0] above_c;

  // lanes and result
  scl_res_t            res      [NUM_AXES];
  logic [NUM_AXES-1:0] busy_vec;
  logic                estop;
  logic [FIELD_W-1:0]  speed_c  [NUM_AXES];

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // ---------------- configuration writes ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_AXES; i++) stick_lim_r[i] <= '0;
      for (int i = 0; i < NUM_SW; i++) sw_lim_r[i] <= '0;
      deadzone_r  <= '0;
      max_speed_r <= '0;
      sw_tol_r    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FWD_LIM:  stick_lim_r[0] <= cfg_data;
        CFG_STR_LIM:  stick_lim_r[1] <= cfg_data;
        CFG_ROT_LIM:  stick_lim_r[2] <= cfg_data;
        CFG_SWA_LIM:  sw_lim_r[0]    <= cfg_data[2*FIELD_W-1:0];
        CFG_SWB_LIM:  sw_lim_r[1]    <= cfg_data[2*FIELD_W-1:0];
        CFG_DEADZONE: deadzone_r     <= cfg_data[FIELD_W-1:0];
        CFG_MAX_SPD:  max_speed_r    <= cfg_data[MAXSPD_W-1:0];
        CFG_SW_TOL:   sw_tol_r       <= cfg_data[FIELD_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- frame age / failsafe ----------------
  always_comb begin
    if (in_frame_done)
      age_nxt = '0;
    else if (age_r < AGE_LIMIT)
      age_nxt = age_r + 1'b1;
    else
      age_nxt = age_r;
  end

  // ---------------- clamp stage: clamp, deadzone edges, switch checks ----------------
  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      lo_c[i] = stick_lim_r[i][FIELD_W-1:0];
      ce_c[i] = stick_lim_r[i][2*FIELD_W-1:FIELD_W];
      hi_c[i] = stick_lim_r[i][3*FIELD_W-1:2*FIELD_W];
      // minimum is tested first so inverted limits behave as the spec says
      if (stick_raw_r[i] < lo_c[i])
        v_c[i] = lo_c[i];
      else if (stick_raw_r[i] > hi_c[i])
        v_c[i] = hi_c[i];
      else
        v_c[i] = stick_raw_r[i];
    end
    for (int j = 0; j < NUM_SW; j++) begin
      sw_up_c[j]   = sw_lim_r[j][FIELD_W-1:0];
      sw_down_c[j] = sw_lim_r[j][2*FIELD_W-1:FIELD_W];
      sw_dist_c[j] = sw_down_c[j] - sw_raw_r[j];
      sw_ok_c[j]   = (sw_raw_r[j] >= sw_up_c[j]) && (sw_raw_r[j] <= sw_down_c[j])
                  && (sw_dist_c[j] <= sw_tol_r);
    end
  end

  // ---------------- setup stage: pick side, distance and span ----------------
  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      below_c[i] = v_r[i] < le_r[i];
      above_c[i] = v_r[i] > ue_r[i];
      if (below_c[i]) begin
        op_c[i].delta = le_r[i] - v_r[i];
        op_c[i].span  = le_r[i] - lo_c[i];
        zero_c[i]     = (le_r[i] <= lo_c[i]);
        neg_c[i]      = !LANE_BELOW_POS[i];
      end else if (above_c[i]) begin
        op_c[i].delta = v_r[i] - ue_r[i];
        op_c[i].span  = hi_c[i] - ue_r[i];
        zero_c[i]     = (hi_c[i] <= ue_r[i]);
        neg_c[i]      = LANE_BELOW_POS[i];
      end else begin
        // inside the deadzone
        op_c[i].delta = '0;
        op_c[i].span  = '0;
        zero_c[i]     = 1'b1;
        neg_c[i]      = 1'b0;
      end
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) busy_vec[i] = res[i].busy;
  end
  assign lanes_busy = |busy_vec;
  assign out_load   = (state_r == S_RUN) && !start_r && !lanes_busy && out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_CLAMP;
      S_CLAMP: state_nxt = S_SETUP;
      S_SETUP: state_nxt = S_RUN;
      S_RUN:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      age_r   <= AGE_LIMIT;
      start_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= (state_r == S_SETUP);
      if (in_acc) age_r <= age_nxt;
    end
  end

  // working registers, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      online_r       <= in_link_up && (age_nxt < AGE_LIMIT);
      stick_raw_r[0] <= in_forward_raw;
      stick_raw_r[1] <= in_strafe_raw;
      stick_raw_r[2] <= in_rotate_raw;
      sw_raw_r[0]    <= in_switch_a_raw;
      sw_raw_r[1]    <= in_switch_b_raw;
    end
    if (state_r == S_CLAMP) begin
      sw_ok_r <= &sw_ok_c;
      for (int i = 0; i < NUM_AXES; i++) begin
        v_r[i]  <= v_c[i];
        le_r[i] <= ce_c[i] - deadzone_r;
        ue_r[i] <= ce_c[i] + deadzone_r;
      end
    end
    if (state_r == S_SETUP) begin
      for (int i = 0; i < NUM_AXES; i++) op_r[i] <= op_c[i];
      neg_r  <= neg_c;
      zero_r <= zero_c;
    end
  end

  // ---------------- axis lanes ----------------
  for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
    rcsm_scaler u_scaler (
      .clk       (clk),
      .rst_n     (rst_n),
      .start     (start_r),
      .op        (op_r[g]),
      .max_speed (max_speed_r),
      .res       (res[g])
    );
  end

  // ---------------- result register ----------------
  assign estop = !(online_r && sw_ok_r);

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      if (estop || zero_r[i])
        speed_c[i] = '0;
      else if (neg_r[i])
        speed_c[i] = -{1'b0, res[i].mag};
      else
        speed_c[i] = {1'b0, res[i].mag};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rx_online    <= online_r;
      out_drive_en     <= !estop;
      out_estop_active <= estop;
      out_fwd_spd      <= speed_c[0];
      out_str_spd      <= speed_c[1];
      out_rot_spd      <= speed_c[2];
    end
  end

endmodule

`default_nettype wire

@@ rtl/rcsm_checker.sv @@
// Port-level checker for rc_channel_to_speed_mapper, bound to the top level.
// Depends on rc_channel_to_speed_mapper_macros.svh.
`default_nettype none

`include "rc_channel_to_speed_mapper_macros.svh"

module rcsm_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        out_rx_online,
  input wire logic        out_drive_en,
  input wire logic        out_estop_active,
  input wire logic [15:0] out_fwd_spd,
  input wire logic [15:0] out_str_spd,
  input wire logic [15:0] out_rot_spd
);

  // a beat is worked one at a time: the input stalls right after acceptance
  `RCSM_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "no stall after accept")

  `RCSM_ASSERT_NOW(a_mode_excl, out_valid, out_estop_active != out_drive_en, "estop/enable clash")

  `RCSM_ASSERT_NOW(a_offline_stops, out_valid && !out_rx_online, out_estop_active, "offline without estop")

  `RCSM_ASSERT_NOW(a_estop_zero, out_valid && out_estop_active, (out_fwd_spd == 16'd0) && (out_str_spd == 16'd0) && (out_rot_spd == 16'd0), "speed during estop")

  `RCSM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_fwd_spd) && $stable(out_estop_active), "stalled result changed")

endmodule

bind rc_channel_to_speed_mapper rcsm_checker u_rcsm_checker (.*);

`default_nettype wire

@@ dv/rc_channel_to_speed_mapper_tb.sv @@
// Self-checking testbench for rc_channel_to_speed_mapper: directed beats, then
// randomized config phases and stick/switch traffic checked by a scoreboard.
// Depends on rcsm_pkg and the mapper RTL only.
`timescale 1ns / 100ps

module rc_channel_to_speed_mapper_tb;
  import rcsm_pkg::*;

  localparam int AGE_LIMIT       = 20;   // TIMEOUT_TICKS of the instance
  localparam int PHASES          = 12;
  localparam int TICKS_PER_PHASE = 140;
  localparam int HOLD_CYCLES     = 400;  // long receiver hold-off
  localparam int DRAIN_CYCLES    = 64;   // slack after the final drain
  localparam int WATCHDOG_LIMIT  = 4000;

  // One input beat: flags plus raw channels.
  typedef struct packed {
    logic               frame_done;
    logic               link_up;
    logic [FIELD_W-1:0] forward;
    logic [FIELD_W-1:0] strafe;
    logic [FIELD_W-1:0] rotate;
    logic [FIELD_W-1:0] switch_a;
    logic [FIELD_W-1:0] switch_b;
  } tick_t;

  // One result beat.
  typedef struct packed {
    logic               online;
    logic               enabled;
    logic               estop;
    logic [FIELD_W-1:0] forward;
    logic [FIELD_W-1:0] strafe;
    logic [FIELD_W-1:0] rotate;
  } speeds_t;

  // Config phase flavors; PH_BENCH is the fixed setup for the directed beats.
  typedef enum int {
    PH_TYPICAL, PH_ALL_ONES, PH_DZ_WRAP, PH_DEGENERATE, PH_INVERTED, PH_ZERO,
    PH_FULL_RANGE, PH_BENCH
  } phase_kind_t;

  // Scoreboard: shadow registers, frame-age tracking and expected speeds.
  class speed_scoreboard;
    logic [47:0]         stick_lim[3];
    logic [31:0]         sw_lim[2];
    logic [FIELD_W-1:0]  deadzone;
    logic [MAXSPD_W-1:0] max_spd;
    logic [FIELD_W-1:0]  sw_tol;
    int unsigned         frame_age;
    int unsigned         age_limit;
    speeds_t             pending_speeds[$];
    int                  errors;

    function new(int unsigned limit);
      age_limit = limit;
      foreach (stick_lim[i]) stick_lim[i] = '0;
      foreach (sw_lim[i]) sw_lim[i] = '0;
      deadzone  = '0;
      max_spd   = '0;
      sw_tol    = '0;
      frame_age = limit;
      errors    = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_FWD_LIM:  stick_lim[0] = data;
        CFG_STR_LIM:  stick_lim[1] = data;
        CFG_ROT_LIM:  stick_lim[2] = data;
        CFG_SWA_LIM:  sw_lim[0] = data[31:0];
        CFG_SWB_LIM:  sw_lim[1] = data[31:0];
        CFG_DEADZONE: deadzone = data[FIELD_W-1:0];
        CFG_MAX_SPD:  max_spd = data[MAXSPD_W-1:0];
        CFG_SW_TOL:   sw_tol = data[FIELD_W-1:0];
        default: ;
      endcase
    endfunction

    function bit switch_armed(logic [FIELD_W-1:0] raw, logic [31:0] lim);
      int unsigned up, down;
      up   = lim[15:0];
      down = lim[31:16];
      if (raw < up || raw > down) return 1'b0;
      return (down - raw) <= sw_tol;
    endfunction

    // delta/span of full deflection times max speed, capped at 32767
    function int unsigned side_scale(int unsigned delta, int unsigned span);
      int unsigned q;
      q = (delta * max_spd) / span;
      return (q > 32767) ? 32767 : q;
    endfunction

    function logic [FIELD_W-1:0] stick_speed(logic [FIELD_W-1:0] raw, logic [47:0] lim,
                                             bit below_pos);
      int unsigned lo, ce, hi, v, lower_e, upper_e, mag;
      bit negative;
      logic [FIELD_W-1:0] spd;
      lo = lim[15:0];
      ce = lim[31:16];
      hi = lim[47:32];
      v  = raw;
      // deadzone edges wrap at 16 bits
      lower_e = (ce - deadzone) & 32'hFFFF;
      upper_e = (ce + deadzone) & 32'hFFFF;
      // min is tested first, so inverted limits can leave v outside a span
      if (v < lo) v = lo;
      else if (v > hi) v = hi;
      if (v < lower_e) begin
        if (lower_e <= lo) return '0;
        mag      = side_scale(lower_e - v, lower_e - lo);
        negative = !below_pos;
      end else if (v > upper_e) begin
        if (hi <= upper_e) return '0;
        mag      = side_scale(v - upper_e, hi - upper_e);
        negative = below_pos;
      end else begin
        return '0;
      end
      spd = negative ? FIELD_W'(0 - mag) : FIELD_W'(mag);
      return spd;
    endfunction

    // Accepted input beat: advance frame age, queue the expected result.
    function void note_tick(tick_t t);
      speeds_t r;
      if (t.frame_done) frame_age = 0;
      else if (frame_age < age_limit) frame_age++;
      r = '0;
      r.online = t.link_up && (frame_age < age_limit);
      if (!r.online || !switch_armed(t.switch_a, sw_lim[0]) ||
          !switch_armed(t.switch_b, sw_lim[1])) begin
        r.estop = 1'b1;
      end else begin
        r.enabled = 1'b1;
        r.forward = stick_speed(t.forward, stick_lim[0], 1'b0);
        r.strafe  = stick_speed(t.strafe, stick_lim[1], 1'b1);
        r.rotate  = stick_speed(t.rotate, stick_lim[2], 1'b1);
      end
      pending_speeds.push_back(r);
    endfunction

    function void check_result(speeds_t got);
      speeds_t want;
      logic [FIELD_W-1:0] w[6];
      logic [FIELD_W-1:0] g[6];
      string field_name[6];
      if (pending_speeds.size() == 0) begin
        $display("%0t: result beat with none expected (fwd %0d)", $time,
                 $signed(got.forward));
        errors++;
        return;
      end
      want = pending_speeds.pop_front();
      field_name = '{"rx_online", "drive_en", "estop_active",
                     "fwd_spd", "str_spd", "rot_spd"};
      w = '{FIELD_W'(want.online), FIELD_W'(want.enabled), FIELD_W'(want.estop),
            want.forward, want.strafe, want.rotate};
      g = '{FIELD_W'(got.online), FIELD_W'(got.enabled), FIELD_W'(got.estop),
            got.forward, got.strafe, got.rotate};
      foreach (w[i]) begin
        if (w[i] !== g[i]) begin
          $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field_name[i],
                   $signed(w[i]), $signed(g[i]));
          errors++;
        end
      end
    endfunction

    function int outstanding();
      return pending_speeds.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_frame_done;
  logic                  in_link_up;
  logic [FIELD_W-1:0]    in_forward_raw;
  logic [FIELD_W-1:0]    in_strafe_raw;
  logic [FIELD_W-1:0]    in_rotate_raw;
  logic [FIELD_W-1:0]    in_switch_a_raw;
  logic [FIELD_W-1:0]    in_switch_b_raw;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_rx_online;
  logic                  out_drive_en;
  logic                  out_estop_active;
  logic signed [FIELD_W-1:0] out_fwd_spd;
  logic signed [FIELD_W-1:0] out_str_spd;
  logic signed [FIELD_W-1:0] out_rot_spd;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  speed_scoreboard sb = new(AGE_LIMIT);

  bit long_hold_req = 1'b0;   // main asks the receiver for a long hold-off
  int drought_left  = 0;      // ticks left in a run without frames
  int idle_cycles   = 0;

  rc_channel_to_speed_mapper #(.TIMEOUT_TICKS(AGE_LIMIT)) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_frame_done    (in_frame_done),
    .in_link_up       (in_link_up),
    .in_forward_raw   (in_forward_raw),
    .in_strafe_raw    (in_strafe_raw),
    .in_rotate_raw    (in_rotate_raw),
    .in_switch_a_raw  (in_switch_a_raw),
    .in_switch_b_raw  (in_switch_b_raw),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_rx_online    (out_rx_online),
    .out_drive_en     (out_drive_en),
    .out_estop_active (out_estop_active),
    .out_fwd_spd      (out_fwd_spd),
    .out_str_spd      (out_str_spd),
    .out_rot_spd      (out_rot_spd),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Result side: check every accepted beat against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result('{out_rx_online, out_drive_en, out_estop_active,
                        out_fwd_spd, out_str_spd, out_rot_spd});
  end

  // Receiver stall pattern: stretches of free flow, light and heavy random
  // stalling and a periodic pattern; a long hold-off when main asks for one.
  initial begin
    int mode = 0;
    int left = 0;
    int hold = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        hold = HOLD_CYCLES;
        long_hold_req = 1'b0;
      end
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(20, 300);
        end
        left--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ((left % 5) < 2);
        endcase
      end
    end
  end

  // Watchdog: nothing accepted on any channel for too long ends the run.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time, sb.outstanding());
      $display("** rc_channel_to_speed_mapper: FAILED **");
      $finish;
    end
  end

  // Offer one input beat after an optional gap; valid stays high on return so
  // back-to-back beats never drop it within one step.
  task automatic send_tick(tick_t t, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_frame_done   <= t.frame_done;
    in_link_up      <= t.link_up;
    in_forward_raw  <= t.forward;
    in_strafe_raw   <= t.strafe;
    in_rotate_raw   <= t.rotate;
    in_switch_a_raw <= t.switch_a;
    in_switch_b_raw <= t.switch_b;
    do @(posedge clk); while (in_stall);
    sb.note_tick(t);
  endtask

  // Sender pause: hold valid low until every expected result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write.
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
  endtask

  // Program all eight registers for one phase. Block must be idle.
  task automatic configure_phase(phase_kind_t kind);
    logic [CFG_DATA_W-1:0] stick[3];
    logic [CFG_DATA_W-1:0] sw[2];
    logic [CFG_DATA_W-1:0] dz, spd, tol;
    int unsigned lo, ce, hi, up, down;
    // typical RC setup first, then the phase bends it
    foreach (stick[a]) begin
      lo = $urandom_range(0, 20000);
      ce = lo + $urandom_range(1, 20000);
      hi = ce + $urandom_range(1, 20000);
      stick[a] = {16'(hi), 16'(ce), 16'(lo)};
    end
    foreach (sw[s]) begin
      up   = $urandom_range(0, 30000);
      down = up + $urandom_range(0, 30000);
      sw[s] = {16'h0, 16'(down), 16'(up)};
    end
    dz  = CFG_DATA_W'($urandom_range(0, 300));
    spd = CFG_DATA_W'($urandom_range(1, 32767));
    tol = CFG_DATA_W'($urandom_range(0, 3000));
    case (kind)
      PH_ALL_ONES: begin
        // every bit set, including bits above each register's width
        foreach (stick[a]) stick[a] = '1;
        foreach (sw[s]) sw[s] = '1;
        dz  = '1;
        spd = '1;
        tol = '1;
      end
      PH_DZ_WRAP: begin
        // centre near an end with a wide deadzone: an edge wraps around
        foreach (stick[a]) begin
          ce = $urandom_range(0, 1) ? $urandom_range(0, 500) : 65535 - $urandom_range(0, 500);
          lo = $urandom_range(0, ce);
          hi = $urandom_range(ce, 65535);
          stick[a] = {16'(hi), 16'(ce), 16'(lo)};
        end
        dz = CFG_DATA_W'($urandom_range(500, 40000));
      end
      PH_DEGENERATE: begin
        // a side of zero span
        foreach (stick[a]) begin
          ce = $urandom_range(0, 65535);
          lo = $urandom_range(0, ce);
          hi = $urandom_range(ce, 65535);
          case ($urandom_range(0, 2))
            0: begin lo = ce; hi = ce; end
            1: lo = ce;
            default: hi = ce;
          endcase
          stick[a] = {16'(hi), 16'(ce), 16'(lo)};
        end
        dz = CFG_DATA_W'($urandom_range(0, 1) ? 0 : $urandom_range(0, 50));
      end
      PH_INVERTED: begin
        // min above max; switches sometimes with up above down
        foreach (stick[a]) begin
          lo = $urandom_range(30000, 65535);
          hi = $urandom_range(0, 30000);
          ce = $urandom_range(0, 65535);
          stick[a] = {16'(hi), 16'(ce), 16'(lo)};
        end
        foreach (sw[s]) begin
          if ($urandom_range(0, 2) == 0) begin
            up   = $urandom_range(30001, 65535);
            down = $urandom_range(0, 30000);
            sw[s] = {16'h0, 16'(down), 16'(up)};
          end
        end
      end
      PH_ZERO: begin
        foreach (stick[a]) stick[a] = '0;
        foreach (sw[s]) sw[s] = '0;
        dz  = '0;
        spd = '0;
        tol = '0;
      end
      PH_FULL_RANGE: begin
        foreach (stick[a]) begin
          ce = $urandom_range(1, 65534);
          stick[a] = {16'hFFFF, 16'(ce), 16'h0};
        end
        foreach (sw[s]) sw[s] = {16'h0, 16'hFFFF, 16'h0};
        dz  = '0;
        spd = CFG_DATA_W'(32767);
        tol = CFG_DATA_W'(16'hFFFF);
      end
      PH_BENCH: begin
        stick[0] = {16'd2000, 16'd1500, 16'd1000};
        stick[1] = {16'd2000, 16'd1500, 16'd1000};
        stick[2] = {16'd60000, 16'd30000, 16'd100};
        sw[0]    = {16'h0, 16'd2000, 16'd1000};
        sw[1]    = {16'h0, 16'd2000, 16'd1000};
        dz  = CFG_DATA_W'(50);
        spd = CFG_DATA_W'(1000);
        tol = CFG_DATA_W'(100);
      end
      default: ;
    endcase
    cfg_write(CFG_FWD_LIM, stick[0]);
    cfg_write(CFG_STR_LIM, stick[1]);
    cfg_write(CFG_ROT_LIM, stick[2]);
    cfg_write(CFG_SWA_LIM, sw[0]);
    cfg_write(CFG_SWB_LIM, sw[1]);
    cfg_write(CFG_DEADZONE, dz);
    cfg_write(CFG_MAX_SPD, spd);
    cfg_write(CFG_SW_TOL, tol);
    cfg_valid <= 1'b0;
  endtask

  function automatic tick_t mk_tick(bit fd, bit lu, logic [15:0] f, logic [15:0] s,
                                    logic [15:0] r, logic [15:0] a, logic [15:0] b);
    return '{fd, lu, f, s, r, a, b};
  endfunction

  // Stick value aimed at the interesting points of the current limits.
  function automatic logic [FIELD_W-1:0] pick_stick(logic [47:0] lim);
    int unsigned lo, ce, hi, le, ue;
    lo = lim[15:0];
    ce = lim[31:16];
    hi = lim[47:32];
    le = (ce - sb.deadzone) & 32'hFFFF;
    ue = (ce + sb.deadzone) & 32'hFFFF;
    case ($urandom_range(0, 15))
      0:  return FIELD_W'(lo);
      1:  return FIELD_W'(hi);
      2:  return FIELD_W'(ce);
      3:  return FIELD_W'(le - 1);
      4:  return FIELD_W'(le);
      5:  return FIELD_W'(le + 1);
      6:  return FIELD_W'(ue - 1);
      7:  return FIELD_W'(ue);
      8:  return FIELD_W'(ue + 1);
      9:  return '0;
      10: return '1;
      11: return FIELD_W'($urandom);
      default: return FIELD_W'($urandom_range(lo, hi));
    endcase
  endfunction

  // Switch value: mostly armed, else around the range and tolerance edges.
  function automatic logic [FIELD_W-1:0] pick_switch(logic [31:0] lim);
    int unsigned up, down, tol, reach;
    up   = lim[15:0];
    down = lim[31:16];
    tol  = sb.sw_tol;
    case ($urandom_range(0, 11))
      0: return FIELD_W'(up);
      1: return FIELD_W'(up - 1);
      2: return FIELD_W'(down + 1);
      3: return FIELD_W'(down - tol);
      4: return FIELD_W'(down - tol - 1);
      5: return FIELD_W'($urandom);
      default: begin
        if (up > down) return FIELD_W'($urandom);
        reach = (tol < down - up) ? tol : down - up;
        return FIELD_W'(down - $urandom_range(0, reach));
      end
    endcase
  endfunction

  // Mostly well-formed ticks: frames arriving, link up, switches armed;
  // runs without frames drive the age through the timeout. Some pure noise.
  function automatic tick_t next_tick();
    tick_t t;
    if ($urandom_range(0, 9) == 0) begin
      t = '{1'($urandom), 1'($urandom), FIELD_W'($urandom), FIELD_W'($urandom),
            FIELD_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom)};
      return t;
    end
    if (drought_left > 0) begin
      drought_left--;
      t.frame_done = 1'b0;
    end else if ($urandom_range(0, 59) == 0) begin
      drought_left = $urandom_range(3, 30);
      t.frame_done = 1'b0;
    end else begin
      t.frame_done = ($urandom_range(0, 7) != 0);
    end
    t.link_up  = ($urandom_range(0, 15) != 0);
    t.forward  = pick_stick(sb.stick_lim[0]);
    t.strafe   = pick_stick(sb.stick_lim[1]);
    t.rotate   = pick_stick(sb.stick_lim[2]);
    t.switch_a = pick_switch(sb.sw_lim[0]);
    t.switch_b = pick_switch(sb.sw_lim[1]);
    return t;
  endfunction

  initial begin
    int burst_left = 0;
    int gap = 0;
    int press_left = 0;
    phase_kind_t kind;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_frame_done   <= 1'b0;
    in_link_up      <= 1'b0;
    in_forward_raw  <= '0;
    in_strafe_raw   <= '0;
    in_rotate_raw   <= '0;
    in_switch_a_raw <= '0;
    in_switch_b_raw <= '0;
    cfg_valid       <= 1'b0;
    cfg_index       <= '0;
    cfg_data        <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset config: starts offline; all-ones switches fail; all-zero arms.
    send_tick(mk_tick(0, 1, 0, 0, 0, 0, 0), 0);
    send_tick(mk_tick(1, 1, '1, '1, '1, '1, '1), 0);
    send_tick(mk_tick(1, 1, 0, 0, 0, 0, 0), 0);
    wait_drained();
    configure_phase(PH_BENCH);

    // Bench setup: sticks 1000/1500/2000 (rotate 100/30000/60000),
    // deadzone 50, switches 1000..2000 with tolerance 100.
    send_tick(mk_tick(1, 1, 1500, 1500, 30000, 2000, 2000), 0);  // centered
    send_tick(mk_tick(1, 1, 1000, 1000, 100, 2000, 2000), 0);    // at min
    send_tick(mk_tick(1, 1, 2000, 2000, 60000, 2000, 2000), 0);  // at max
    send_tick(mk_tick(1, 1, 0, 0, 0, 1900, 1900), 0);            // clamp low, tol edge
    send_tick(mk_tick(1, 1, '1, '1, '1, 1899, 2000), 0);         // clamp high, out of tol
    send_tick(mk_tick(1, 1, 1449, 1551, 29949, 2000, 2000), 0);  // just past deadzone
    send_tick(mk_tick(1, 1, 1450, 1550, 30050, 2000, 2000), 0);  // on deadzone edges
    send_tick(mk_tick(1, 1, 1200, 1800, 5000, 2001, 2000), 0);   // switch above down
    send_tick(mk_tick(1, 1, 1200, 1800, 5000, 2000, 999), 0);    // switch below up
    send_tick(mk_tick(1, 0, 1200, 1800, 5000, 2000, 2000), 0);   // link down
    send_tick(mk_tick(0, 1, 1700, 1300, 50000, 2000, 2000), 0);  // no frame, still young
    send_tick(mk_tick(1, 1, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA), 0);
    send_tick(mk_tick(1, 1, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555), 0);

    // Random part: each phase reprograms everything while idle, then runs
    // bursty traffic. Some phases include a long receiver hold-off with
    // back-to-back input so the block backs up; every phase has a mid-phase pause.
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      kind = phase_kind_t'((p < 7) ? p : $urandom_range(0, 6));
      configure_phase(kind);
      for (int i = 0; i < TICKS_PER_PHASE; i++) begin
        if (i == 40 && (p % 4) == 1) begin
          long_hold_req = 1'b1;
          press_left = 10;
        end
        if (i == 90) wait_drained();
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end else begin
          gap = 0;
        end
        burst_left--;
        if (press_left > 0) begin
          gap = 0;
          press_left--;
        end
        send_tick(next_tick(), gap);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("** rc_channel_to_speed_mapper: PASSED **");
    end else begin
      $display("** rc_channel_to_speed_mapper: FAILED **");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/rcsm_pkg.sv
rtl/rcsm_scaler.sv
rtl/rc_channel_to_speed_mapper.sv
rtl/rcsm_checker.sv
dv/rc_channel_to_speed_mapper_tb.sv
